### src/tsnp_pkg.sv
package tsnp_pkg;

   localparam int MAX_TOKEN_LEN = 31;
   localparam int VALUE_WIDTH   = 64;
   localparam int HELD_WIDTH    = $clog2(MAX_TOKEN_LEN + 1);

   localparam int CHAR_WIDTH  = 8;
   localparam int INDEX_WIDTH = 5;
   localparam int BASE_WIDTH  = 6;
   localparam int OUT_VALUE_WIDTH = 64;

   localparam logic [BASE_WIDTH-1:0] BASE_RESET = 6'd10;

   localparam logic [CHAR_WIDTH-1:0] CHAR_EOI       = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS     = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE      = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [CHAR_WIDTH-1:0] UPCASE_MASK    = 8'hDF;
   localparam logic [BASE_WIDTH-1:0] LETTER_DIGIT_OFFSET = 6'd10;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0]             token_char;
      logic [INDEX_WIDTH-1:0]            char_index;
      logic                              end_of_token;
      logic [INDEX_WIDTH-1:0]            token_length;
      logic                              is_number;
      logic signed [OUT_VALUE_WIDTH-1:0] number_value;
      logic                              input_exhausted;
   } rsp_item_type;

endpackage

### src/tsnp_req_if.sv
interface tsnp_req_if;
   logic                                valid;
   logic                                ready;
   logic [tsnp_pkg::CHAR_WIDTH-1:0]     in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

### src/tsnp_rsp_if.sv
interface tsnp_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic [tsnp_pkg::CHAR_WIDTH-1:0]             token_char;
   logic [tsnp_pkg::INDEX_WIDTH-1:0]            char_index;
   logic                                        end_of_token;
   logic [tsnp_pkg::INDEX_WIDTH-1:0]            token_length;
   logic                                        is_number;
   logic signed [tsnp_pkg::OUT_VALUE_WIDTH-1:0] number_value;
   logic                                        input_exhausted;

   modport source (output valid, output token_char, output char_index, output end_of_token,
                   output token_length, output is_number, output number_value,
                   output input_exhausted, input ready);
   modport sink (input valid, input token_char, input char_index, input end_of_token,
                 input token_length, input is_number, input number_value,
                 input input_exhausted, output ready);
endinterface

### src/tsnp_scan_core.sv
module tsnp_scan_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_en,
   input  logic [tsnp_pkg::CHAR_WIDTH-1:0]     step_char,
   input  logic [tsnp_pkg::BASE_WIDTH-1:0]     number_base,
   output logic                                res_valid,
   output tsnp_pkg::rsp_item_type              res_item
);

   typedef enum logic [1:0] {
      MODE_SKIP    = 2'd0,
      MODE_COMMENT = 2'd1,
      MODE_TOKEN   = 2'd2
   } mode_type;

   mode_type                               mode_ff, mode_in;
   logic [tsnp_pkg::HELD_WIDTH-1:0]        held_ff, held_in;
   logic [tsnp_pkg::VALUE_WIDTH-1:0]       acc_ff, acc_in;
   logic                                   minus_ff, minus_in;
   logic                                   dvalid_ff, dvalid_in;
   logic                                   dseen_ff, dseen_in;

   logic [tsnp_pkg::CHAR_WIDTH-1:0]        ch;
   logic                                   is_digit;
   logic [tsnp_pkg::BASE_WIDTH-1:0]        digit;
   logic                                   starting;
   logic [tsnp_pkg::VALUE_WIDTH-1:0]       acc_src;
   logic                                   minus_src, dvalid_src, dseen_src;
   logic [tsnp_pkg::HELD_WIDTH-1:0]        idx_src;
   logic [tsnp_pkg::VALUE_WIDTH-1:0]       acc_next;
   logic                                   minus_next, dvalid_next, dseen_next;
   logic signed [tsnp_pkg::VALUE_WIDTH-1:0] close_value;

   // upper-case and digit decode
   always_comb begin
      ch = step_char;
      if (step_char >= tsnp_pkg::CHAR_LOWER_A && step_char <= tsnp_pkg::CHAR_LOWER_Z) begin
         ch = step_char & tsnp_pkg::UPCASE_MASK;
      end
      is_digit = 1'b0;
      digit    = '0;
      if (ch >= tsnp_pkg::CHAR_ZERO && ch <= tsnp_pkg::CHAR_NINE) begin
         is_digit = 1'b1;
         digit    = tsnp_pkg::BASE_WIDTH'(ch - tsnp_pkg::CHAR_ZERO);
      end else if (ch >= tsnp_pkg::CHAR_UPPER_A && ch <= tsnp_pkg::CHAR_UPPER_Z) begin
         is_digit = 1'b1;
         digit    = tsnp_pkg::BASE_WIDTH'(ch - tsnp_pkg::CHAR_UPPER_A)
                    + tsnp_pkg::LETTER_DIGIT_OFFSET;
      end
   end

   // number state seen by this item: cleared when it opens a token
   assign starting   = (mode_ff != MODE_TOKEN);
   assign acc_src    = starting ? '0 : acc_ff;
   assign minus_src  = starting ? 1'b0 : minus_ff;
   assign dvalid_src = starting ? 1'b1 : dvalid_ff;
   assign dseen_src  = starting ? 1'b0 : dseen_ff;
   assign idx_src    = starting ? '0 : held_ff;

   always_comb begin
      acc_next    = acc_src;
      minus_next  = minus_src;
      dvalid_next = dvalid_src;
      dseen_next  = dseen_src;
      if (idx_src == '0 && ch == tsnp_pkg::CHAR_MINUS) begin
         minus_next = 1'b1;
      end else if (!is_digit || digit >= number_base) begin
         dvalid_next = 1'b0;
      end else if (dvalid_src) begin
         acc_next   = acc_src * tsnp_pkg::VALUE_WIDTH'(number_base)
                      + tsnp_pkg::VALUE_WIDTH'(digit);
         dseen_next = 1'b1;
      end
   end

   assign close_value = minus_ff ? -acc_ff : acc_ff;

   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      acc_in    = acc_ff;
      minus_in  = minus_ff;
      dvalid_in = dvalid_ff;
      dseen_in  = dseen_ff;
      res_valid = 1'b0;
      res_item  = '0;
      unique case (mode_ff)
         MODE_COMMENT: begin
            if (ch == tsnp_pkg::CHAR_EOI) begin
               mode_in                  = MODE_SKIP;
               res_valid                = 1'b1;
               res_item.end_of_token    = 1'b1;
               res_item.input_exhausted = 1'b1;
            end else if (ch == tsnp_pkg::CHAR_NEWLINE) begin
               mode_in = MODE_SKIP;
            end
         end
         MODE_TOKEN: begin
            res_valid = 1'b1;
            if (ch > tsnp_pkg::CHAR_SPACE &&
                held_ff < tsnp_pkg::HELD_WIDTH'(tsnp_pkg::MAX_TOKEN_LEN)) begin
               acc_in              = acc_next;
               minus_in            = minus_next;
               dvalid_in           = dvalid_next;
               dseen_in            = dseen_next;
               held_in             = held_ff + 1'b1;
               res_item.token_char = ch;
               res_item.char_index = tsnp_pkg::INDEX_WIDTH'(held_ff);
            end else begin
               res_item.end_of_token = 1'b1;
               res_item.token_length = tsnp_pkg::INDEX_WIDTH'(held_ff);
               res_item.is_number    = dvalid_ff && dseen_ff;
               if (dvalid_ff && dseen_ff) begin
                  res_item.number_value = tsnp_pkg::OUT_VALUE_WIDTH'(close_value);
               end
               mode_in   = MODE_SKIP;
               held_in   = '0;
               acc_in    = '0;
               minus_in  = 1'b0;
               dvalid_in = 1'b1;
               dseen_in  = 1'b0;
            end
         end
         default: begin
            mode_in = MODE_SKIP;
            if (ch == tsnp_pkg::CHAR_EOI) begin
               res_valid                = 1'b1;
               res_item.end_of_token    = 1'b1;
               res_item.input_exhausted = 1'b1;
            end else if (ch == tsnp_pkg::CHAR_BACKSLASH) begin
               mode_in = MODE_COMMENT;
            end else if (ch > tsnp_pkg::CHAR_SPACE) begin
               mode_in             = MODE_TOKEN;
               acc_in              = acc_next;
               minus_in            = minus_next;
               dvalid_in           = dvalid_next;
               dseen_in            = dseen_next;
               held_in             = tsnp_pkg::HELD_WIDTH'(1);
               res_valid           = 1'b1;
               res_item.token_char = ch;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SKIP;
         held_ff   <= '0;
         acc_ff    <= '0;
         minus_ff  <= 1'b0;
         dvalid_ff <= 1'b1;
         dseen_ff  <= 1'b0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         acc_ff    <= acc_in;
         minus_ff  <= minus_in;
         dvalid_ff <= dvalid_in;
         dseen_ff  <= dseen_in;
      end
   end

endmodule

### src/token_scanner_number_parser.sv
// Scans a byte stream into upper-cased tokens, one byte per item, and parses each token as
// a signed number in the base held in the csr register (reset 10). Every stored token byte
// gives one result with its index; the byte that ends a token gives a closing result with
// the length, the number flag and the 64-bit value; end of input between tokens gives an
// empty closing result with input_exhausted set. Blanks, and backslash comments up to the
// newline, give no result. An item is registered on entry and its result is registered on
// exit, so a byte can be taken every cycle while the receiver is ready; the single 64 by
// 6 bit multiply-add of the digit accumulator sets the clock.
// Write the base only while the block is idle.
module token_scanner_number_parser (
   input  logic                              clock,
   input  logic                              reset,
   tsnp_req_if.sink                          req_ch,
   tsnp_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_en,
   input  logic [tsnp_pkg::BASE_WIDTH-1:0]   csr_write_data
);

   logic [tsnp_pkg::BASE_WIDTH-1:0] base_ff;
   logic                            in_valid_ff, in_valid_in;
   logic [tsnp_pkg::CHAR_WIDTH-1:0] in_char_ff;
   logic                            out_valid_ff, out_valid_in;
   tsnp_pkg::rsp_item_type          out_item_ff;
   logic                            advance;
   logic                            res_valid;
   tsnp_pkg::rsp_item_type          res_item;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res_valid;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   tsnp_scan_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .step_char   (in_char_ff),
      .number_base (base_ff),
      .res_valid   (res_valid),
      .res_item    (res_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= tsnp_pkg::BASE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            base_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_char_ff <= req_ch.in_char;
      end
      if (advance && res_valid) begin
         out_item_ff <= res_item;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.token_char      = out_item_ff.token_char;
   assign rsp_ch.char_index      = out_item_ff.char_index;
   assign rsp_ch.end_of_token    = out_item_ff.end_of_token;
   assign rsp_ch.token_length    = out_item_ff.token_length;
   assign rsp_ch.is_number       = out_item_ff.is_number;
   assign rsp_ch.number_value    = out_item_ff.number_value;
   assign rsp_ch.input_exhausted = out_item_ff.input_exhausted;

endmodule

### tb/tb.sv
module tb;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 11;
   localparam int MAX_WAIT     = 12;
   localparam int SETTLE       = 4;
   localparam int TAIL         = 8;
   localparam int STALL_LIMIT  = 400;
   localparam int RANDOM_ITEMS = 1500;

   typedef enum logic [1:0] {SCAN_BLANKS, SCAN_COMMENT, SCAN_TOKEN} scan_mode_type;
   typedef enum logic [1:0] {SEND_CHAR, SEND_BASE, SEND_DRAIN} send_kind_type;

   typedef struct packed {
      send_kind_type                   kind;
      logic [tsnp_pkg::CHAR_WIDTH-1:0] data;
   } text_entry_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_en;
   logic [tsnp_pkg::BASE_WIDTH-1:0] csr_write_data;

   tsnp_req_if req_ch();
   tsnp_rsp_if rsp_ch();

   token_scanner_number_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   text_entry_type         text_stream[$];
   tsnp_pkg::rsp_item_type token_results_due[$];

   // scanner state mirrored by the predictor
   scan_mode_type                   scan_mode;
   logic [tsnp_pkg::BASE_WIDTH-1:0] radix;
   int unsigned                     held;
   logic [63:0]                     digit_acc;
   bit                              minus_seen;
   bit                              digits_ok;
   bit                              digit_seen;

   logic [tsnp_pkg::BASE_WIDTH-1:0] gen_radix = tsnp_pkg::BASE_RESET;
   bit req_taken, rsp_taken;
   bit req_idle_on = 1;
   bit rsp_idle_on = 1;
   bit timed_out;
   int req_gap, rsp_gap;
   int quiet_cycles, stall_cycles, errors;
   int chars_total, chars_taken, results_checked;
   int tokens_closed, numbers_closed, exhaust_count, base_writes;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void clear_number();
      digit_acc  = '0;
      minus_seen = 0;
      digits_ok  = 1;
      digit_seen = 0;
   endfunction

   function automatic void reset_scanner();
      scan_mode = SCAN_BLANKS;
      radix     = tsnp_pkg::BASE_RESET;
      held      = 0;
      clear_number();
   endfunction

   function automatic void take_digit(logic [tsnp_pkg::CHAR_WIDTH-1:0] c, int unsigned pos);
      int unsigned d;
      if (pos == 0 && c == tsnp_pkg::CHAR_MINUS) begin
         minus_seen = 1;
      end else if (c < tsnp_pkg::CHAR_ZERO) begin
         digits_ok = 0;
      end else begin
         if (c <= tsnp_pkg::CHAR_NINE)
            d = int'(c - tsnp_pkg::CHAR_ZERO);
         else if (c >= tsnp_pkg::CHAR_UPPER_A && c <= tsnp_pkg::CHAR_UPPER_Z)
            d = int'(tsnp_pkg::LETTER_DIGIT_OFFSET) + int'(c - tsnp_pkg::CHAR_UPPER_A);
         else
            d = 64;
         if (d >= radix)
            digits_ok = 0;
         else if (digits_ok) begin
            digit_acc  = digit_acc * 64'(radix) + 64'(d);
            digit_seen = 1;
         end
      end
   endfunction

   function automatic void scan_byte(logic [tsnp_pkg::CHAR_WIDTH-1:0] raw);
      logic [tsnp_pkg::CHAR_WIDTH-1:0] c;
      tsnp_pkg::rsp_item_type          r;
      c = raw;
      if (c >= tsnp_pkg::CHAR_LOWER_A && c <= tsnp_pkg::CHAR_LOWER_Z)
         c = c & tsnp_pkg::UPCASE_MASK;
      r = '0;
      case (scan_mode)
         SCAN_COMMENT: begin
            if (c == tsnp_pkg::CHAR_EOI) begin
               scan_mode         = SCAN_BLANKS;
               r.end_of_token    = 1;
               r.input_exhausted = 1;
               token_results_due.push_back(r);
            end else if (c == tsnp_pkg::CHAR_NEWLINE) begin
               scan_mode = SCAN_BLANKS;
            end
         end
         SCAN_TOKEN: begin
            if (c > tsnp_pkg::CHAR_SPACE && held < tsnp_pkg::MAX_TOKEN_LEN) begin
               take_digit(c, held);
               r.token_char = c;
               r.char_index = tsnp_pkg::INDEX_WIDTH'(held);
               held++;
            end else begin
               r.end_of_token = 1;
               r.token_length = tsnp_pkg::INDEX_WIDTH'(held);
               r.is_number    = digits_ok && digit_seen;
               if (r.is_number)
                  r.number_value = minus_seen ? -digit_acc : digit_acc;
               scan_mode = SCAN_BLANKS;
               held      = 0;
               clear_number();
            end
            token_results_due.push_back(r);
         end
         default: begin
            scan_mode = SCAN_BLANKS;
            if (c == tsnp_pkg::CHAR_EOI) begin
               r.end_of_token    = 1;
               r.input_exhausted = 1;
               token_results_due.push_back(r);
            end else if (c == tsnp_pkg::CHAR_BACKSLASH) begin
               scan_mode = SCAN_COMMENT;
            end else if (c > tsnp_pkg::CHAR_SPACE) begin
               clear_number();
               take_digit(c, 0);
               r.token_char = c;
               held         = 1;
               scan_mode    = SCAN_TOKEN;
               token_results_due.push_back(r);
            end
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   function automatic bit block_settled();
      return token_results_due.size() == 0 && quiet_cycles >= SETTLE;
   endfunction

   function automatic void send_char(logic [tsnp_pkg::CHAR_WIDTH-1:0] c);
      text_stream.push_back('{SEND_CHAR, c});
      chars_total++;
   endfunction

   function automatic void send_text(string s);
      foreach (s[i])
         send_char(s[i]);
   endfunction

   function automatic void send_base(int b);
      text_stream.push_back('{SEND_BASE, tsnp_pkg::CHAR_WIDTH'(b)});
      gen_radix = tsnp_pkg::BASE_WIDTH'(b);
   endfunction

   function automatic void send_drain();
      text_stream.push_back('{SEND_DRAIN, tsnp_pkg::CHAR_EOI});
   endfunction

   function automatic logic [tsnp_pkg::CHAR_WIDTH-1:0] digit_char(int d, bit lower);
      logic [tsnp_pkg::CHAR_WIDTH-1:0] c;
      if (d < 10)
         c = tsnp_pkg::CHAR_ZERO + tsnp_pkg::CHAR_WIDTH'(d);
      else
         c = tsnp_pkg::CHAR_UPPER_A + tsnp_pkg::CHAR_WIDTH'(d - 10);
      if (lower && d >= 10)
         c = c | ~tsnp_pkg::UPCASE_MASK;
      return c;
   endfunction

   // mostly numbers in the current base, with words, full-length tokens,
   // comments, raw noise and end-of-input markers mixed in
   function automatic void fill_random(int count);
      int stop, sel, n, hi;
      logic [tsnp_pkg::CHAR_WIDTH-1:0] c;
      stop = chars_total + count;
      while (chars_total < stop) begin
         sel = $urandom_range(0, 99);
         hi  = (gen_radix == 0) ? 0 : ((gen_radix > 36) ? 35 : gen_radix - 1);
         if (sel < 55) begin
            if ($urandom_range(0, 3) == 0)
               send_char(tsnp_pkg::CHAR_MINUS);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            repeat (n) begin
               if ($urandom_range(0, 19) == 0)
                  send_char(digit_char($urandom_range(0, 35), $urandom_range(0, 1)));
               else
                  send_char(digit_char($urandom_range(0, hi), $urandom_range(0, 2) == 0));
            end
         end else if (sel < 68) begin
            n = $urandom_range(1, 8);
            repeat (n)
               send_char(tsnp_pkg::CHAR_WIDTH'($urandom_range(33, 255)));
         end else if (sel < 74) begin
            n = $urandom_range(0, 1) ? 31 : $urandom_range(29, 34);
            repeat (n)
               send_char(digit_char($urandom_range(0, hi), 0));
            if ($urandom_range(0, 2) == 0)
               send_char(tsnp_pkg::CHAR_EOI);
         end else if (sel < 80) begin
            send_char(tsnp_pkg::CHAR_BACKSLASH);
            n = $urandom_range(0, 8);
            repeat (n) begin
               c = tsnp_pkg::CHAR_WIDTH'($urandom_range(1, 255));
               send_char(c == tsnp_pkg::CHAR_NEWLINE ? tsnp_pkg::CHAR_SPACE : c);
            end
            send_char($urandom_range(0, 3) == 0 ? tsnp_pkg::CHAR_EOI : tsnp_pkg::CHAR_NEWLINE);
         end else if (sel < 90) begin
            n = $urandom_range(1, 4);
            repeat (n)
               send_char(tsnp_pkg::CHAR_WIDTH'($urandom_range(0, 255)));
         end else begin
            send_char(tsnp_pkg::CHAR_EOI);
         end
         n = $urandom_range(1, 2);
         repeat (n) begin
            case ($urandom_range(0, 3))
               0, 1: send_char(tsnp_pkg::CHAR_SPACE);
               2: send_char(tsnp_pkg::CHAR_NEWLINE);
               default: send_char(tsnp_pkg::CHAR_WIDTH'($urandom_range(1, 32)));
            endcase
         end
         if ($urandom_range(0, 39) == 0)
            send_drain();
      end
   endfunction

   // sample at the rising edge: check results, then predict from accepted items
   always @(posedge clock) begin
      tsnp_pkg::rsp_item_type seen;
      tsnp_pkg::rsp_item_type due;
      req_taken = 0;
      rsp_taken = 0;
      if (reset) begin
         reset_scanner();
         token_results_due.delete();
         quiet_cycles = 0;
         stall_cycles = 0;
      end else begin
         if (csr_write_en) begin
            radix = csr_write_data;
            base_writes++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken = 1;
            seen.token_char      = rsp_ch.token_char;
            seen.char_index      = rsp_ch.char_index;
            seen.end_of_token    = rsp_ch.end_of_token;
            seen.token_length    = rsp_ch.token_length;
            seen.is_number       = rsp_ch.is_number;
            seen.number_value    = rsp_ch.number_value;
            seen.input_exhausted = rsp_ch.input_exhausted;
            if (token_results_due.size() == 0) begin
               $error("unexpected result item: %p", seen);
               errors++;
            end else begin
               due = token_results_due.pop_front();
               results_checked++;
               check_field("token_char", due.token_char, seen.token_char);
               check_field("char_index", due.char_index, seen.char_index);
               check_field("end_of_token", due.end_of_token, seen.end_of_token);
               check_field("token_length", due.token_length, seen.token_length);
               check_field("is_number", due.is_number, seen.is_number);
               check_field("number_value", due.number_value, seen.number_value);
               check_field("input_exhausted", due.input_exhausted, seen.input_exhausted);
               if (due.input_exhausted)
                  exhaust_count++;
               else if (due.end_of_token) begin
                  tokens_closed++;
                  if (due.is_number)
                     numbers_closed++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1;
            chars_taken++;
            scan_byte(req_ch.in_char);
         end
         if (req_taken || rsp_taken || csr_write_en)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (req_taken || token_results_due.size() != 0)
            quiet_cycles = 0;
         else if (quiet_cycles < 1000)
            quiet_cycles++;
      end
   end

   // byte sender; base writes and drains wait for the block to go quiet
   always @(negedge clock) begin
      text_entry_type                  head;
      logic                            nxt_valid;
      logic                            nxt_we;
      logic [tsnp_pkg::CHAR_WIDTH-1:0] nxt_char;
      logic [tsnp_pkg::BASE_WIDTH-1:0] nxt_base;
      nxt_valid = req_ch.valid && !req_taken;
      nxt_char  = req_ch.in_char;
      nxt_we    = 0;
      nxt_base  = csr_write_data;
      if (reset) begin
         nxt_valid = 0;
         nxt_char  = tsnp_pkg::CHAR_EOI;
         nxt_base  = tsnp_pkg::BASE_RESET;
      end else if (!nxt_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (text_stream.size() > 0) begin
            head = text_stream[0];
            case (head.kind)
               SEND_CHAR: begin
                  nxt_valid = 1;
                  nxt_char  = head.data;
                  void'(text_stream.pop_front());
                  if ($urandom_range(0, 59) == 0)
                     req_idle_on = !req_idle_on;
                  req_gap = req_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
               end
               SEND_BASE: begin
                  if (block_settled()) begin
                     nxt_we   = 1;
                     nxt_base = head.data[tsnp_pkg::BASE_WIDTH-1:0];
                     void'(text_stream.pop_front());
                  end
               end
               default: begin
                  if (block_settled())
                     void'(text_stream.pop_front());
               end
            endcase
         end
      end
      req_ch.valid   <= nxt_valid;
      req_ch.in_char <= nxt_char;
      csr_write_en   <= nxt_we;
      csr_write_data <= nxt_base;
   end

   // result receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 59) == 0)
               rsp_idle_on = !rsp_idle_on;
            rsp_gap = rsp_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   initial begin
      int radix_plan[$];
      int target;
      clock = 0;
      reset = 1;

      // negative, lower case, comment, lone minus, backslash inside a token,
      // end of input inside a token, a comment and between tokens, top-bit bytes
      send_text("-7 az \\c\n- a\\b");
      send_char(tsnp_pkg::CHAR_EOI);
      send_char(tsnp_pkg::CHAR_BACKSLASH);
      send_char(tsnp_pkg::CHAR_EOI);
      send_char(tsnp_pkg::CHAR_NINE);
      send_char(tsnp_pkg::CHAR_EOI);
      send_char(tsnp_pkg::CHAR_EOI);
      send_char(8'hFF);
      send_char(8'h80);
      send_char(8'h01);

      target = chars_total + RANDOM_ITEMS;
      radix_plan = '{2, 36, 16, 0, 8, 1, 63, 10};
      foreach (radix_plan[i]) begin
         send_drain();
         send_base(radix_plan[i]);
         fill_random((radix_plan[i] < 2 || radix_plan[i] > 36) ? 60 : 150);
      end
      while (chars_total < target) begin
         send_base($urandom_range(2, 36));
         fill_random(150);
      end
      send_char(tsnp_pkg::CHAR_EOI);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 0;

      while (!(chars_taken == chars_total && token_results_due.size() == 0
               && quiet_cycles >= TAIL)) begin
         @(negedge clock);
         if (stall_cycles >= STALL_LIMIT) begin
            timed_out = 1;
            break;
         end
      end

      if (timed_out)
         $display("no handshake for %0d cycles", STALL_LIMIT);
      if (token_results_due.size() != 0)
         $error("%0d result items never arrived", token_results_due.size());
      $display("Scanned %0d of %0d bytes: %0d tokens closed, %0d numeric, %0d end-of-input",
               chars_taken, chars_total, tokens_closed, numbers_closed, exhaust_count);
      $display("%0d result items checked over %0d base settings", results_checked,
               base_writes);
      if (errors == 0 && !timed_out && token_results_due.size() == 0)
         $display("token_scanner_number_parser verification clean");
      else
         $display("token_scanner_number_parser verification failed");
      $finish;
   end

endmodule
